@@ design/assert_macros.svh @@
// Assertion macros used by the table's top-level RTL file.
// Expects clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is applied.
`define OKVT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form of the same.
`define OKVT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/okvt_pkg.sv @@
// Package for the ordered key/value table: sizes, operation codes and
// the request/result transfer types. No dependencies.
package okvt_pkg;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned KEY_WIDTH   = 32;
  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);

  localparam logic [6:0] CAP_RESET = 7'd64;

  localparam logic [2:0] MODE_INSERT  = 3'd0;
  localparam logic [2:0] MODE_UPDATE  = 3'd1;
  localparam logic [2:0] MODE_UPSERT  = 3'd2;
  localparam logic [2:0] MODE_ERASE   = 3'd3;
  localparam logic [2:0] MODE_GET_KEY = 3'd4;
  localparam logic [2:0] MODE_GET_IDX = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] key;
    logic [63:0] new_value;
    logic [5:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] key_out;
    logic [63:0] value_out;
    logic [6:0]  entry_count;
  } rsp_t;

endpackage

@@ design/okvt_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module okvt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ordered_key_value_table_unit.sv @@
// Ordered key/value table: top level with sequencer and one key comparator.
// Depends on okvt_pkg, okvt_ram and assert_macros.svh.
//
// Usage:
//   A request transfers when start_i is high and busy_o is low. The block
//   then holds busy_o high until it has finished, unless it finishes from
//   idle; the result shows on rsp_o with done_o high for exactly one cycle.
//   The receiver cannot stall; a new request may transfer in that cycle.
//   Entries live in two RAMs (keys, values) with a registered read. One
//   comparator walks the occupied entries from position 0, one entry per
//   cycle, and stops at the first match.
//   Steps: get by index reads the entry in S_IDX; an index out of range
//   finishes from idle. Key operations scan in S_SCAN, or finish from idle
//   on an empty table; erase then moves each later entry down in S_SHIFT.
//   Configuration: cfg_we_i writes cfg_wdata_i to the capacity limit at once;
//   write it only while idle. Reset empties the table, sets the limit to 64
//   and drops any request in flight; RAM contents are not cleared.
`include "assert_macros.svh"

module ordered_key_value_table_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  okvt_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output okvt_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_wdata_i
);
  import okvt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_IDX   = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       ptr_q, ptr_d;
  logic [6:0]             cap_q;
  req_t                   req_q, req_d, cur;
  logic                   done_q, done_d;
  rsp_t                   rsp_q, rsp_d;

  logic [CNT_W-1:0]       limit, ptr_inc;
  logic [IDX_W-1:0]       rd_addr, wr_addr;
  logic                   key_we, val_we;
  logic [KEY_WIDTH-1:0]   wr_key, key_rd;
  logic [VALUE_WIDTH-1:0] wr_val, val_rd;
  logic                   fin, fin_ok;
  logic [31:0]            fin_kout;
  logic [63:0]            fin_vout;

  okvt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_key),
    .raddr_i (rd_addr),
    .rdata_o (key_rd)
  );

  okvt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_val),
    .raddr_i (rd_addr),
    .rdata_o (val_rd)
  );

  assign limit   = ({{(32-7){1'b0}}, cap_q} < DEPTH) ? CNT_W'(cap_q) : CNT_W'(DEPTH);
  assign ptr_inc = ptr_q + CNT_W'(1);
  assign cur     = (state_q == S_IDLE) ? req_i : req_q;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    req_d    = req_q;
    rd_addr  = '0;
    wr_addr  = '0;
    key_we   = 1'b0;
    val_we   = 1'b0;
    wr_key   = cur.key[KEY_WIDTH-1:0];
    wr_val   = cur.new_value[VALUE_WIDTH-1:0];
    fin      = 1'b0;
    fin_ok   = 1'b0;
    fin_kout = '0;
    fin_vout = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          ptr_d = '0;
          if (req_i.mode == MODE_GET_IDX) begin
            if (CNT_W'(req_i.entry_index) < count_q) begin
              rd_addr = req_i.entry_index[IDX_W-1:0];
              state_d = S_IDX;
            end else begin
              fin = 1'b1;
            end
          end else if (req_i.mode > MODE_GET_KEY) begin
            fin = 1'b1;
          end else if (count_q != '0) begin
            rd_addr = '0;
            state_d = S_SCAN;
          end else begin
            // empty table: key is absent
            fin = 1'b1;
            if ((req_i.mode == MODE_INSERT || req_i.mode == MODE_UPSERT) &&
                count_q < limit) begin
              key_we  = 1'b1;
              val_we  = 1'b1;
              wr_addr = count_q[IDX_W-1:0];
              count_d = count_q + CNT_W'(1);
              fin_ok  = 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        if (key_rd == req_q.key[KEY_WIDTH-1:0]) begin
          case (req_q.mode) inside
            MODE_UPDATE, MODE_UPSERT: begin
              val_we  = 1'b1;
              wr_addr = ptr_q[IDX_W-1:0];
              fin     = 1'b1;
              fin_ok  = 1'b1;
            end
            MODE_ERASE: begin
              if (ptr_inc < count_q) begin
                rd_addr = ptr_inc[IDX_W-1:0];
                state_d = S_SHIFT;
              end else begin
                count_d = count_q - CNT_W'(1);
                fin     = 1'b1;
                fin_ok  = 1'b1;
              end
            end
            MODE_GET_KEY: begin
              fin      = 1'b1;
              fin_ok   = 1'b1;
              fin_vout = 64'(val_rd);
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end else if (ptr_inc < count_q) begin
          rd_addr = ptr_inc[IDX_W-1:0];
          ptr_d   = ptr_inc;
        end else begin
          fin = 1'b1;
          if ((req_q.mode == MODE_INSERT || req_q.mode == MODE_UPSERT) &&
              count_q < limit) begin
            key_we  = 1'b1;
            val_we  = 1'b1;
            wr_addr = count_q[IDX_W-1:0];
            count_d = count_q + CNT_W'(1);
            fin_ok  = 1'b1;
          end
        end
      end
      S_IDX: begin
        fin      = 1'b1;
        fin_ok   = 1'b1;
        fin_kout = 32'(key_rd);
        fin_vout = 64'(val_rd);
      end
      S_SHIFT: begin
        // move entry ptr+1 down to ptr
        key_we  = 1'b1;
        val_we  = 1'b1;
        wr_addr = ptr_q[IDX_W-1:0];
        wr_key  = key_rd;
        wr_val  = val_rd;
        ptr_d   = ptr_inc;
        if ((ptr_inc + CNT_W'(1)) < count_q) begin
          rd_addr = ptr_inc[IDX_W-1:0] + IDX_W'(1);
        end else begin
          count_d = count_q - CNT_W'(1);
          fin     = 1'b1;
          fin_ok  = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = S_IDLE;
    end
    done_d            = fin;
    rsp_d             = rsp_q;
    if (fin) begin
      rsp_d.ok          = fin_ok;
      rsp_d.key_out     = fin_kout;
      rsp_d.value_out   = fin_vout;
      rsp_d.entry_count = 7'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      cap_q   <= CAP_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `OKVT_ASSERT(a_count_max, count_q <= CNT_W'(DEPTH), "entry count above depth")
  `OKVT_ASSERT_IMP(a_accept_progress, start_i && !busy_o, ##1 (busy_o || done_o), "request lost")
  `OKVT_ASSERT_IMP(a_shift_erase, state_q == S_SHIFT, req_q.mode == MODE_ERASE, "shift outside erase")
  `OKVT_ASSERT_IMP(a_done_count, done_o, rsp_o.entry_count == 7'(count_q), "result count stale")

endmodule
